@@ hdl/ipss_pkg.sv @@
// package for the instrument power and scan sequencer
// types, field widths, step windows and event codes; no dependencies
package ipss_pkg;

    localparam int STEP_NOW_BITS = 13;
    localparam int GROUP_BITS    = 3;
    localparam int STEP_BITS_DEF = 13;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_ADDR_BITS = 1;
    localparam int IN_TDATA_BITS = 40;
    localparam int OUT_TDATA_BITS = 32;

    localparam logic [2:0] GROUP_MASK = 3'((1 << GROUP_BITS) - 1);

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_PROGRAM_ENABLE = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_COOL_SETPOINT  = 1'd1;

    // camera status codes
    localparam logic [7:0] STATUS_INIT_DONE = 8'd10;
    localparam logic [7:0] STATUS_SCAN_DONE = 8'd30;

    // step marks
    localparam int STEP_INIT_LO    = 5;
    localparam int STEP_INIT_TO    = 50;
    localparam int STEP_COOL_ENTRY = 1000;
    localparam int STEP_COOL_LO    = 1005;
    localparam int STEP_COOL_TO    = 1900;
    localparam int STEP_SCAN_ENTRY = 2000;
    localparam int STEP_START_LO   = 2005;
    localparam int STEP_LOOP_ENTRY = 3000;
    localparam int STEP_LOOP_LO    = 3005;
    localparam int STEP_LOOP_TO    = 3900;
    localparam int STEP_WARM_ENTRY = 4000;
    localparam int STEP_WARM_LO    = 4005;
    localparam int STEP_OFF_ENTRY  = 5000;
    localparam int STEP_OFF_LO     = 5002;

    localparam int TEMP_LASER_MARGIN = 5;
    localparam logic signed [15:0] TEMP_WARM = 16'sd180;
    localparam logic [1:0] RETRY_MAX = 2'd3;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_POWER_ON    = 4'd1,
        EV_INIT_FAIL   = 4'd2,
        EV_INIT_DONE   = 4'd3,
        EV_COOLER_FAIL = 4'd4,
        EV_LASER_ON    = 4'd5,
        EV_SCAN_START  = 4'd6,
        EV_SCAN_FAIL   = 4'd7,
        EV_SCAN_NEXT   = 4'd8,
        EV_SCAN_LAST   = 4'd9,
        EV_WARM        = 4'd10,
        EV_OFF         = 4'd11
    } ipss_event_t;

    typedef struct packed {
        logic               data_valid;
        logic signed [15:0] cooler_temp;
        logic [7:0]         camera_status;
        logic [7:0]         scan_count;
        logic [2:0]         settings_group;
        logic [2:0]         power_group;
        logic               power_match;
    } ipss_in_t;

    typedef struct packed {
        logic [STEP_NOW_BITS-1:0] step_now;
        ipss_event_t              event_code;
        logic                     scan_start;
        logic                     camera_init;
        logic                     cooler_power;
        logic                     laser_power;
        logic                     camera_power;
        logic [2:0]               load_group;
        logic                     load_settings;
        logic                     transfer_data;
    } ipss_result_t;

    typedef struct packed {
        logic [1:0] retry_count;
        logic [7:0] scan_index;
        logic       camera_on;
        logic       laser_on;
        logic       cooler_on;
    } ipss_state_t;

endpackage

@@ hdl/ipss_core.sv @@
// per-tick sequencing logic: next state and result from one request
// depends on ipss_pkg
module ipss_core #(
    parameter int STEP_BITS = ipss_pkg::STEP_BITS_DEF
) (
    input  ipss_pkg::ipss_in_t     item,
    input  logic                   program_enable,
    input  logic signed [15:0]     cool_setpoint,
    input  logic [STEP_BITS-1:0]   step,
    input  ipss_pkg::ipss_state_t  state,
    output logic [STEP_BITS-1:0]   step_next,
    output ipss_pkg::ipss_state_t  state_next,
    output ipss_pkg::ipss_result_t result
);
    import ipss_pkg::*;

    localparam logic [STEP_BITS-1:0] STEP_ONE = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};

    logic [STEP_BITS-1:0] s;
    logic [STEP_BITS-1:0] step_adv;
    logic signed [17:0]   laser_limit;
    logic signed [17:0]   temp_ext;

    assign laser_limit = 18'(cool_setpoint) + 18'(TEMP_LASER_MARGIN);
    assign temp_ext    = 18'(item.cooler_temp);

    always_comb
    begin
        state_next = state;
        step_adv   = step;
        result     = '0;
        result.event_code    = EV_NONE;
        result.transfer_data = item.data_valid && (step == '0);

        if (program_enable)
        begin
            if (item.power_match)
            begin
                state_next.scan_index  = 8'd1;
                state_next.retry_count = 2'd0;
                state_next.camera_on   = 1'b1;
                result.load_settings   = 1'b1;
                result.load_group      = item.settings_group & GROUP_MASK;
                result.event_code      = EV_POWER_ON;
                step_adv               = STEP_ONE;
            end
            if (step_adv != STEP_MAX)
            begin
                step_adv = step_adv + STEP_ONE;
            end
        end

        s         = step_adv;
        step_next = step_adv;

        if (s > STEP_BITS'(STEP_INIT_LO) && s < STEP_BITS'(STEP_COOL_ENTRY))
        begin
            if (s > STEP_BITS'(STEP_INIT_TO))
            begin
                if (state_next.retry_count < RETRY_MAX)
                begin
                    state_next.retry_count = state_next.retry_count + 2'd1;
                    result.camera_init     = 1'b1;
                    step_next              = STEP_ONE;
                end
                else
                begin
                    result.event_code = EV_INIT_FAIL;
                    step_next         = STEP_BITS'(STEP_OFF_ENTRY);
                end
            end
            else if (item.camera_status == STATUS_INIT_DONE)
            begin
                result.event_code    = EV_INIT_DONE;
                state_next.cooler_on = 1'b1;
                step_next            = STEP_BITS'(STEP_COOL_ENTRY);
            end
        end
        else if (s > STEP_BITS'(STEP_COOL_LO) && s < STEP_BITS'(STEP_SCAN_ENTRY))
        begin
            if (s > STEP_BITS'(STEP_COOL_TO))
            begin
                result.event_code = EV_COOLER_FAIL;
                step_next         = STEP_BITS'(STEP_WARM_ENTRY);
            end
            else if (temp_ext < laser_limit)
            begin
                result.event_code   = EV_LASER_ON;
                state_next.laser_on = 1'b1;
                step_next           = STEP_BITS'(STEP_SCAN_ENTRY);
            end
        end
        else if (s > STEP_BITS'(STEP_START_LO) && s < STEP_BITS'(STEP_LOOP_ENTRY))
        begin
            if (item.cooler_temp < cool_setpoint)
            begin
                result.event_code = EV_SCAN_START;
                result.scan_start = 1'b1;
                step_next         = STEP_BITS'(STEP_LOOP_ENTRY);
            end
        end
        else if (s > STEP_BITS'(STEP_LOOP_LO) && s < STEP_BITS'(STEP_WARM_ENTRY))
        begin
            if (s > STEP_BITS'(STEP_LOOP_TO))
            begin
                result.event_code    = EV_SCAN_FAIL;
                state_next.laser_on  = 1'b0;
                state_next.cooler_on = 1'b0;
                step_next            = STEP_BITS'(STEP_WARM_ENTRY);
            end
            else if (item.camera_status == STATUS_SCAN_DONE)
            begin
                if (state_next.scan_index != 8'hff)
                begin
                    state_next.scan_index = state_next.scan_index + 8'd1;
                end
                if (state.scan_index < item.scan_count)
                begin
                    result.event_code = EV_SCAN_NEXT;
                    result.scan_start = 1'b1;
                    step_next         = STEP_BITS'(STEP_LOOP_ENTRY);
                end
                else
                begin
                    result.event_code    = EV_SCAN_LAST;
                    state_next.laser_on  = 1'b0;
                    state_next.cooler_on = 1'b0;
                    step_next            = STEP_BITS'(STEP_WARM_ENTRY);
                end
            end
        end
        else if (s > STEP_BITS'(STEP_WARM_LO) && s < STEP_BITS'(STEP_OFF_ENTRY))
        begin
            if (item.cooler_temp > TEMP_WARM)
            begin
                result.event_code = EV_WARM;
                step_next         = STEP_BITS'(STEP_OFF_ENTRY);
            end
        end
        else if (s > STEP_BITS'(STEP_OFF_LO))
        begin
            result.event_code    = EV_OFF;
            state_next.camera_on = 1'b0;
            state_next.laser_on  = 1'b0;
        end

        result.camera_power = state_next.camera_on;
        result.laser_power  = state_next.laser_on;
        result.cooler_power = state_next.cooler_on;
        result.step_now     = step_next[STEP_NOW_BITS-1:0];
    end

endmodule

@@ hdl/instrument_power_scan_sequencer.sv @@
// Power and scan sequencer for a camera, cooler and laser instrument. One
// request is one one-second tick; the block accepts a new request every
// cycle unless s_tready is low. The request is held in an input register,
// then the sequencing logic runs and updates the step counter and on-flags
// while the result register is loaded. s_tready drops only while both
// registers are full and the result is not taken. The user must write
// program_enable and cool_setpoint through the cfg port only while no
// request is in flight; the block itself does not enforce this.
// top level; depends on ipss_pkg and ipss_core
module instrument_power_scan_sequencer #(
    parameter int STEP_BITS = ipss_pkg::STEP_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ipss_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [ipss_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // power_match, power_group[3], settings_group[3], scan_count[8],
    // camera_status[8], cooler_temp[16], data_valid
    input  logic [ipss_pkg::IN_TDATA_BITS-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // transfer_data, load_settings, load_group[3], camera_power, laser_power,
    // cooler_power, camera_init, scan_start, event_code[4], step_now[13], zeros
    output logic [ipss_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);
    import ipss_pkg::*;

    localparam int RES_BITS = $bits(ipss_result_t);

    logic                  program_enable_reg;
    logic signed [15:0]    cool_setpoint_reg;
    logic                  in_valid_reg;
    ipss_in_t              in_data_reg;
    logic                  out_valid_reg;
    ipss_result_t          out_data_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [STEP_BITS-1:0]  step_next;
    ipss_state_t           state_reg;
    ipss_state_t           state_next;
    ipss_result_t          result;
    logic                  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS - RES_BITS){1'b0}}, out_data_reg};

    ipss_core #(
        .STEP_BITS (STEP_BITS)
    ) u_core (
        .item           (in_data_reg),
        .program_enable (program_enable_reg),
        .cool_setpoint  (cool_setpoint_reg),
        .step           (step_reg),
        .state          (state_reg),
        .step_next      (step_next),
        .state_next     (state_next),
        .result         (result)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_enable_reg <= 1'b0;
            cool_setpoint_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PROGRAM_ENABLE: program_enable_reg <= cfg_wdata[0];
                REG_COOL_SETPOINT:  cool_setpoint_reg  <= $signed(cfg_wdata);
                default:            ;
            endcase
        end
    end

    // control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= step_next;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= ipss_in_t'(s_tdata);
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    a_init_retry_step : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.camera_init |->
            out_data_reg.step_now == STEP_NOW_BITS'(1) && out_data_reg.event_code == EV_NONE)
        else $error("camera init pulse without step restart");

    a_scan_start_step : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.scan_start |->
            out_data_reg.step_now == STEP_NOW_BITS'(STEP_LOOP_ENTRY))
        else $error("scan start pulse with wrong step");

    a_load_power_on : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.load_settings |->
            out_data_reg.camera_power && out_data_reg.event_code == EV_POWER_ON)
        else $error("settings load without camera power on");

    a_advance_result : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && step_reg[STEP_NOW_BITS-1:0] == out_data_reg.step_now)
        else $error("result register out of step with sequencer state");

endmodule

@@ dv/tb_top.sv @@
// self-checking bench for instrument_power_scan_sequencer: table-driven and random ticks
// checked against a tick-level predictor of the power and scan sequence
// depends on ipss_pkg and the sequencer rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ipss_pkg::*;

    localparam int PERIOD_NS      = 10;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RAND_PHASES    = 12;
    localparam int RAND_PER_PHASE = 100;

    localparam logic [12:0] STEP_TOP = 13'h1fff;

    localparam int INIT_LO       = 5;
    localparam int INIT_TIMEOUT  = 50;
    localparam int COOL_ENTRY    = 1000;
    localparam int COOL_LO       = 1005;
    localparam int COOL_TIMEOUT  = 1900;
    localparam int START_ENTRY   = 2000;
    localparam int START_LO      = 2005;
    localparam int LOOP_ENTRY    = 3000;
    localparam int LOOP_LO       = 3005;
    localparam int LOOP_TIMEOUT  = 3900;
    localparam int WARM_ENTRY    = 4000;
    localparam int WARM_LO       = 4005;
    localparam int OFF_ENTRY     = 5000;
    localparam int OFF_LO        = 5002;
    localparam int LASER_MARGIN  = 5;
    localparam int WARM_TEMP     = 180;

    localparam logic [7:0] CAM_INIT_DONE = 8'd10;
    localparam logic [7:0] CAM_SCAN_DONE = 8'd30;

    typedef struct {
        bit                          is_cfg;
        logic [CFG_ADDR_BITS-1:0]    addr;
        logic [15:0]                 wdata;
        int                          reps;
        bit                          typed;
        ipss_in_t                    item;
        ipss_result_t                want;
    } plan_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0]    cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_wdata = '0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [IN_TDATA_BITS-1:0]    s_tdata = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]   m_tdata;

    // predictor copy of the sequencer state and registers
    logic              prog_en;
    logic signed [15:0] setpoint;
    logic [12:0]       step_q;
    logic [1:0]        retries;
    logic [7:0]        scan_idx;
    logic              cam_on;
    logic              las_on;
    logic              cool_on;

    ipss_result_t due_results[$];
    plan_row_t    plan[$];

    int send_gap_pct;
    int recv_stall_pct;
    int noise_pct;
    int restart_pct;
    int match_pct;
    int count_pin;
    int resp_pct[6];
    int fail_count = 0;
    int ticks_sent;
    int results_seen = 0;
    int cycle_count = 0;
    bit event_seen[16];

    instrument_power_scan_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #(PERIOD_NS / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("instrument_power_scan_sequencer regression: fail");
            $finish;
        end
    end

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic [7:0] avoid_code(input logic [7:0] v, input logic [7:0] code);
        return (v == code) ? (v ^ 8'h01) : v;
    endfunction

    function automatic int step_band();
        if (step_q < COOL_ENTRY)
            return 0;
        if (step_q < START_ENTRY)
            return 1;
        if (step_q < LOOP_ENTRY)
            return 2;
        if (step_q < WARM_ENTRY)
            return 3;
        if (step_q < OFF_ENTRY)
            return 4;
        return 5;
    endfunction

    // one tick of the sequencer, updating the predictor state
    function automatic ipss_result_t run_tick(input ipss_in_t it);
        ipss_result_t r;
        int           s;
        int           t;
        int           sp;
        bit           more;
        r = '0;
        r.event_code = EV_NONE;
        t = int'(it.cooler_temp);
        sp = int'(setpoint);
        r.transfer_data = it.data_valid && (step_q == 0);
        if (prog_en)
        begin
            if (it.power_match)
            begin
                scan_idx = 8'd1;
                retries = 2'd0;
                r.load_settings = 1'b1;
                r.load_group = it.settings_group & GROUP_MASK;
                cam_on = 1'b1;
                step_q = 13'd1;
                r.event_code = EV_POWER_ON;
            end
            if (step_q != STEP_TOP)
                step_q = step_q + 13'd1;
        end
        s = int'(step_q);
        if (s > INIT_LO && s < COOL_ENTRY)
        begin
            if (s > INIT_TIMEOUT)
            begin
                if (retries < 2'd3)
                begin
                    retries = retries + 2'd1;
                    r.camera_init = 1'b1;
                    step_q = 13'd1;
                end
                else
                begin
                    r.event_code = EV_INIT_FAIL;
                    step_q = 13'(OFF_ENTRY);
                end
            end
            else if (it.camera_status == CAM_INIT_DONE)
            begin
                r.event_code = EV_INIT_DONE;
                cool_on = 1'b1;
                step_q = 13'(COOL_ENTRY);
            end
        end
        if (s > COOL_LO && s < START_ENTRY)
        begin
            if (s > COOL_TIMEOUT)
            begin
                r.event_code = EV_COOLER_FAIL;
                step_q = 13'(WARM_ENTRY);
            end
            else if (t < sp + LASER_MARGIN)
            begin
                r.event_code = EV_LASER_ON;
                las_on = 1'b1;
                step_q = 13'(START_ENTRY);
            end
        end
        if (s > START_LO && s < LOOP_ENTRY && t < sp)
        begin
            r.event_code = EV_SCAN_START;
            r.scan_start = 1'b1;
            step_q = 13'(LOOP_ENTRY);
        end
        if (s > LOOP_LO && s < WARM_ENTRY)
        begin
            if (s > LOOP_TIMEOUT)
            begin
                r.event_code = EV_SCAN_FAIL;
                las_on = 1'b0;
                cool_on = 1'b0;
                step_q = 13'(WARM_ENTRY);
            end
            else if (it.camera_status == CAM_SCAN_DONE)
            begin
                more = scan_idx < it.scan_count;
                if (scan_idx != 8'd255)
                    scan_idx = scan_idx + 8'd1;
                if (more)
                begin
                    r.event_code = EV_SCAN_NEXT;
                    r.scan_start = 1'b1;
                    step_q = 13'(LOOP_ENTRY);
                end
                else
                begin
                    r.event_code = EV_SCAN_LAST;
                    las_on = 1'b0;
                    cool_on = 1'b0;
                    step_q = 13'(WARM_ENTRY);
                end
            end
        end
        if (s > WARM_LO && s < OFF_ENTRY && t > WARM_TEMP)
        begin
            r.event_code = EV_WARM;
            step_q = 13'(OFF_ENTRY);
        end
        if (s > OFF_LO)
        begin
            r.event_code = EV_OFF;
            cam_on = 1'b0;
            las_on = 1'b0;
        end
        r.camera_power = cam_on;
        r.laser_power = las_on;
        r.cooler_power = cool_on;
        r.step_now = step_q;
        return r;
    endfunction

    // next tick request, steered by the predicted stage
    function automatic ipss_in_t gen_tick();
        ipss_in_t    it;
        logic [63:0] raw;
        int          band;
        int          sp;
        int          r;
        int          pick;
        bit          hit;
        raw = {$urandom, $urandom};
        it = raw[IN_TDATA_BITS-1:0];
        if ($urandom_range(0, 99) < noise_pct)
            return it;
        sp = int'(setpoint);
        band = step_band();
        r = $urandom_range(0, 3);
        it.power_match = 1'b0;
        if (step_q == 0 || step_q > OFF_LO)
        begin
            if (prog_en && $urandom_range(0, 99) < restart_pct)
            begin
                it.power_match = 1'b1;
                case ($urandom_range(0, 2))
                    0: pick = 60;
                    1: pick = 30;
                    default: pick = 10;
                endcase
                resp_pct = '{pick, pick, pick, pick, pick, pick};
            end
        end
        else if ($urandom_range(0, 99) < match_pct)
            it.power_match = 1'b1;
        if (count_pin >= 0)
            it.scan_count = 8'(count_pin);
        else if ($urandom_range(0, 9) < 7)
            it.scan_count = 8'($urandom_range(0, 4));
        hit = $urandom_range(0, 99) < resp_pct[band];
        case (band)
            0: it.camera_status = hit ? CAM_INIT_DONE : avoid_code(it.camera_status, CAM_INIT_DONE);
            1: it.cooler_temp = sat16(hit ? sp + LASER_MARGIN - 1 - r : sp + LASER_MARGIN + r);
            2: it.cooler_temp = sat16(hit ? sp - 1 - r : sp + r);
            3: it.camera_status = hit ? CAM_SCAN_DONE : avoid_code(it.camera_status, CAM_SCAN_DONE);
            4: it.cooler_temp = sat16(hit ? WARM_TEMP + 1 + r : WARM_TEMP - r);
            default:
            begin
                if ($urandom_range(0, 4) == 0)
                    it.cooler_temp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
        endcase
        return it;
    endfunction

    function automatic ipss_in_t req(input bit m, input int pg, input int sg, input int cnt,
                                     input int st, input int temp, input bit dv);
        ipss_in_t it;
        it.power_match = m;
        it.power_group = pg[2:0];
        it.settings_group = sg[2:0];
        it.scan_count = cnt[7:0];
        it.camera_status = st[7:0];
        it.cooler_temp = temp[15:0];
        it.data_valid = dv;
        return it;
    endfunction

    function automatic ipss_result_t res(input bit xf, input bit ld, input int lg, input bit cam,
                                         input bit las, input bit cool, input ipss_event_t ev,
                                         input int step);
        ipss_result_t r;
        r = '0;
        r.transfer_data = xf;
        r.load_settings = ld;
        r.load_group = lg[2:0];
        r.camera_power = cam;
        r.laser_power = las;
        r.cooler_power = cool;
        r.event_code = ev;
        r.step_now = step[12:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_setpoint(input int ph);
        int sel;
        sel = $urandom_range(0, 9);
        case (ph)
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7fff;
            default:
            begin
                if (sel < 5)
                    return 16'($urandom_range(0, 600)) - 16'd300;
                if (sel < 8)
                    return 16'($urandom);
                return sel[0] ? 16'h7fff : 16'h8000;
            end
        endcase
    endfunction

    function automatic void match_field(input string field, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    task automatic send_tick(input ipss_in_t it, input bit typed, input ipss_result_t want);
        ipss_result_t pred;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= it;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = run_tick(it);
        due_results.push_back(typed ? want : pred);
        ticks_sent++;
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr, input logic [15:0] data);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_PROGRAM_ENABLE)
            prog_en = data[0];
        else
            setpoint = data;
    endtask

    // one full power-on run with fixed response odds per stage, until switched off
    task automatic long_run(input int r0, input int r1, input int r2, input int r3,
                            input int r4, input int cnt);
        ipss_in_t it;
        resp_pct = '{r0, r1, r2, r3, r4, 0};
        count_pin = cnt;
        it = gen_tick();
        it.power_match = 1'b1;
        send_tick(it, 1'b0, '0);
        while (step_q <= OFF_LO)
            send_tick(gen_tick(), 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        ipss_result_t got;
        ipss_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(ipss_result_t)-1:0];
                results_seen++;
                event_seen[got.event_code] = 1'b1;
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no request pending, expected none actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = due_results.pop_front();
                    match_field("transfer_data", int'(want.transfer_data),
                                int'(got.transfer_data));
                    match_field("load_settings", int'(want.load_settings),
                                int'(got.load_settings));
                    match_field("load_group", int'(want.load_group), int'(got.load_group));
                    match_field("camera_power", int'(want.camera_power),
                                int'(got.camera_power));
                    match_field("laser_power", int'(want.laser_power), int'(got.laser_power));
                    match_field("cooler_power", int'(want.cooler_power),
                                int'(got.cooler_power));
                    match_field("camera_init", int'(want.camera_init), int'(got.camera_init));
                    match_field("scan_start", int'(want.scan_start), int'(got.scan_start));
                    match_field("event_code", int'(want.event_code), int'(got.event_code));
                    match_field("step_now", int'(want.step_now), int'(got.step_now));
                    match_field("tdata padding", 0,
                                int'(m_tdata[OUT_TDATA_BITS-1:$bits(ipss_result_t)]));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int kinds;
        prog_en = 1'b0;
        setpoint = '0;
        step_q = '0;
        retries = '0;
        scan_idx = '0;
        cam_on = 1'b0;
        las_on = 1'b0;
        cool_on = 1'b0;
        ticks_sent = 0;
        noise_pct = 0;
        restart_pct = 0;
        match_pct = 0;
        count_pin = -1;
        resp_pct = '{50, 50, 50, 50, 50, 50};
        send_gap_pct = 0;
        recv_stall_pct = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk: disabled ticks, power on and restart, then init, cooling and scan start into the scan loop
        plan.push_back('{0, '0, '0, 1, 1, req(1, 7, 7, 255, 255, 32767, 1),
                        res(1, 0, 0, 0, 0, 0, EV_NONE, 0)});
        plan.push_back('{0, '0, '0, 1, 1, req(0, 0, 0, 0, 0, 0, 0),
                        res(0, 0, 0, 0, 0, 0, EV_NONE, 0)});
        plan.push_back('{1, REG_PROGRAM_ENABLE, 16'h0001, 0, 0, '0, '0});
        plan.push_back('{1, REG_COOL_SETPOINT, 16'h8000, 0, 0, '0, '0});
        plan.push_back('{0, '0, '0, 1, 1, req(1, 7, 7, 255, 0, 0, 1),
                        res(1, 1, 7, 1, 0, 0, EV_POWER_ON, 2)});
        plan.push_back('{0, '0, '0, 1, 1, req(0, 0, 0, 0, 0, 0, 1),
                        res(0, 0, 0, 1, 0, 0, EV_NONE, 3)});
        plan.push_back('{0, '0, '0, 1, 1, req(1, 5, 2, 0, 0, 0, 0),
                        res(0, 1, 2, 1, 0, 0, EV_POWER_ON, 2)});
        plan.push_back('{0, '0, '0, 4, 0, req(0, 0, 0, 1, 10, 0, 0), '0});
        plan.push_back('{0, '0, '0, 6, 0, req(0, 0, 0, 1, 0, -32768, 0), '0});
        plan.push_back('{1, REG_PROGRAM_ENABLE, 16'h0000, 0, 0, '0, '0});
        plan.push_back('{0, '0, '0, 1, 1, req(1, 3, 3, 0, 30, -32768, 1),
                        res(0, 0, 0, 1, 1, 1, EV_NONE, 2000)});
        plan.push_back('{1, REG_COOL_SETPOINT, 16'h7fff, 0, 0, '0, '0});
        plan.push_back('{1, REG_PROGRAM_ENABLE, 16'h0001, 0, 0, '0, '0});
        plan.push_back('{0, '0, '0, 6, 0, req(0, 0, 0, 1, 0, 32766, 0), '0});
        plan.push_back('{0, '0, '0, 6, 0, req(0, 0, 0, 255, 30, 0, 0), '0});

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].addr, plan[i].wdata);
            else
                repeat (plan[i].reps) send_tick(plan[i].item, plan[i].typed, plan[i].want);
        end

        // random sequences with noise and interrupted runs
        noise_pct = 10;
        restart_pct = 25;
        match_pct = 1;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph < RAND_PHASES / 3)
            begin
                send_gap_pct = 22;
                recv_stall_pct = 45;
            end
            else if (ph < 2 * RAND_PHASES / 3)
            begin
                send_gap_pct = 45;
                recv_stall_pct = 22;
            end
            else
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            write_reg(REG_COOL_SETPOINT, pick_setpoint(ph));
            write_reg(REG_PROGRAM_ENABLE, (ph % 5 == 3) ? 16'h0000 : 16'h0001);
            repeat (RAND_PER_PHASE) send_tick(gen_tick(), 1'b0, '0);
        end

        // long runs: every timeout, scan index and step counter saturation
        noise_pct = 0;
        restart_pct = 0;
        match_pct = 0;
        write_reg(REG_COOL_SETPOINT, 16'h0000);
        write_reg(REG_PROGRAM_ENABLE, 16'h0001);
        long_run(0, 0, 0, 0, 0, -1);
        long_run(100, 0, 100, 100, 0, -1);
        long_run(100, 100, 100, 0, 100, -1);
        long_run(100, 100, 100, 100, 100, 255);
        resp_pct = '{0, 0, 0, 0, 0, 0};
        count_pin = -1;
        while (step_q != STEP_TOP)
            send_tick(gen_tick(), 1'b0, '0);
        repeat (4) send_tick(gen_tick(), 1'b0, '0);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        kinds = 0;
        foreach (event_seen[k])
            kinds += int'(event_seen[k]);
        $display("ticks sent %0d, results checked %0d, mismatches %0d",
                 ticks_sent, results_seen, fail_count);
        $display("event codes observed: %0d of 12, including all stage timeouts", kinds);
        if (fail_count == 0 && due_results.size() == 0)
            $display("instrument_power_scan_sequencer regression: pass");
        else
            $display("instrument_power_scan_sequencer regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
hdl/ipss_pkg.sv
hdl/ipss_core.sv
hdl/instrument_power_scan_sequencer.sv
dv/tb_top.sv
